// ===== src/tti_pkg.sv =====
// Thermistor table interpolator: shared constants, calibration tables,
// controller/datapath command and status types. No dependencies.
package tti_pkg;

  localparam int TableEntriesDef = 25;
  localparam int NumTablesDef    = 2;

  localparam int CodeW   = 16;
  localparam int TempW   = 11;
  localparam int QuotW   = 6;
  localparam int SegStep = 50;
  localparam int BaseOff = 200;
  localparam int MulW    = CodeW + QuotW;
  localparam int AccW    = 16;

  localparam int CalTables  = 2;
  localparam int CalEntries = 25;

  localparam logic [CodeW-1:0] CalTab [CalTables][CalEntries] = '{
    '{16'h65B6, 16'h64EE, 16'h63FD, 16'h62DD, 16'h618A, 16'h5FFF, 16'h5E35, 16'h5C29,
      16'h59D6, 16'h573D, 16'h545E, 16'h513F, 16'h4DE5, 16'h4A5A, 16'h46A7, 16'h42D8,
      16'h3EF7, 16'h3B10, 16'h372D, 16'h335A, 16'h2F9F, 16'h2C05, 16'h2894, 16'h2552,
      16'h2242},
    '{16'h91C7, 16'h8DD7, 16'h88F6, 16'h8313, 16'h7C29, 16'h7446, 16'h6B90, 16'h623E,
      16'h5897, 16'h4EE8, 16'h457B, 16'h3C90, 16'h3454, 16'h2CE4, 16'h264C, 16'h2088,
      16'h1B8F, 16'h174F, 16'h13B3, 16'h10A7, 16'h0E17, 16'h0BEF, 16'h0A21, 16'h089D,
      16'h0757}
  };

  // entries beyond the calibrated tables read as zero
  function automatic logic [CodeW-1:0] cal_entry(input logic [1:0] row,
                                                 input logic [5:0] idx);
    logic [CodeW-1:0] v;
    v = '0;
    if (row < 2'(CalTables) && idx < 6'(CalEntries)) begin
      v = CalTab[row[0]][idx[4:0]];
    end
    return v;
  endfunction

  typedef struct packed {
    logic load;
    logic search_step;
    logic prep;
    logic div_step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic search_last;
    logic div_last;
  } status_t;

endpackage

// ===== src/tti_if.sv =====
// Valid/ready channel interfaces for the thermistor table interpolator.
// Depends on tti_pkg for field widths.
interface tti_in_if;
  logic                       valid;
  logic                       ready;
  logic [tti_pkg::CodeW-1:0]  adc_code;
  logic                       sensor_select;
  modport source (output valid, adc_code, sensor_select, input ready);
  modport sink   (input valid, adc_code, sensor_select, output ready);
endinterface

interface tti_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [tti_pkg::TempW-1:0] temperature_tenths;
  logic                             in_range;
  logic                             sensor_echo;
  modport source (output valid, temperature_tenths, in_range, sensor_echo, input ready);
  modport sink   (input valid, temperature_tenths, in_range, sensor_echo, output ready);
endinterface

// ===== src/tti_ctrl.sv =====
// Sequencing controller: search, prepare, divide, emit.
// Depends on tti_pkg for the command and status types.
module tti_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output tti_pkg::cmd_t    cmd_o,
  input  tti_pkg::status_t status_i
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SEARCH = 5'b00010,
    S_PREP   = 5'b00100,
    S_DIVIDE = 5'b01000,
    S_FINISH = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SEARCH;
        end
      end
      S_SEARCH: begin
        cmd_o.search_step = 1'b1;
        if (status_i.search_last) begin
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = S_DIVIDE;
      end
      S_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== src/tti_datapath.sv =====
// Datapath: range check, bitwise segment search over the calibration
// table, restoring divider and result register. Depends on tti_pkg.
module tti_datapath #(
  parameter int TABLE_ENTRIES = tti_pkg::TableEntriesDef,
  parameter int NUM_TABLES    = tti_pkg::NumTablesDef
) (
  input  logic                             clk_i,
  input  tti_pkg::cmd_t                    cmd_i,
  output tti_pkg::status_t                 status_o,
  input  logic [tti_pkg::CodeW-1:0]        adc_code_i,
  input  logic                             sensor_select_i,
  output logic signed [tti_pkg::TempW-1:0] temperature_o,
  output logic                             in_range_o,
  output logic                             sensor_echo_o
);

  localparam int KW      = (TABLE_ENTRIES > 2) ? $clog2(TABLE_ENTRIES - 1) : 1;
  localparam int RW      = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
  localparam int LastSeg = TABLE_ENTRIES - 2;
  localparam int CW      = (tti_pkg::QuotW > 1) ? $clog2(tti_pkg::QuotW) : 1;
  localparam int CodeW   = tti_pkg::CodeW;
  localparam int MulW    = tti_pkg::MulW;
  localparam int AccW    = tti_pkg::AccW;

  logic [CodeW-1:0]         code_q;
  logic                     sel_q;
  logic [RW-1:0]            row_q;
  logic                     range_q;
  logic [KW-1:0]            seg_q;
  logic [KW-1:0]            mask_q;
  logic [MulW-1:0]          num_q;
  logic [CodeW-1:0]         den_q;
  logic [tti_pkg::QuotW-1:0] quot_q;
  logic [CW-1:0]            cnt_q;

  logic signed [tti_pkg::TempW-1:0] temp_q;
  logic                             range_out_q;
  logic                             sel_out_q;

  logic [RW-1:0]    row_in;
  logic [CodeW-1:0] first_in, last_in;
  logic [KW-1:0]    probe;
  logic             probe_ok;
  logic [CodeW-1:0] hi, lo, diff, span;
  logic [MulW-1:0]  trial;
  logic signed [AccW-1:0] base, temp;
  logic             round_up;

  always_comb begin
    if (32'(sensor_select_i) < NUM_TABLES) begin
      row_in = RW'(sensor_select_i);
    end else begin
      row_in = RW'(NUM_TABLES - 1);
    end
    first_in = tti_pkg::cal_entry(2'(row_in), 6'(0));
    last_in  = tti_pkg::cal_entry(2'(row_in), 6'(TABLE_ENTRIES - 1));

    probe    = seg_q | mask_q;
    probe_ok = (32'(probe) <= LastSeg) &&
               (tti_pkg::cal_entry(2'(row_q), 6'(probe)) >= code_q);

    hi   = tti_pkg::cal_entry(2'(row_q), 6'(seg_q));
    lo   = tti_pkg::cal_entry(2'(row_q), 6'(32'(seg_q) + 1));
    diff = hi - code_q;
    span = hi - lo;

    trial = MulW'(den_q) << cnt_q;

    // truncation toward zero: negative segments round the fraction up
    base     = AccW'(tti_pkg::SegStep) * AccW'(seg_q) - AccW'(tti_pkg::BaseOff);
    round_up = base[AccW-1] && (num_q != '0);
    temp     = base + AccW'(quot_q) + AccW'(round_up);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      code_q  <= adc_code_i;
      sel_q   <= sensor_select_i;
      row_q   <= row_in;
      range_q <= (adc_code_i <= first_in) && (adc_code_i > last_in);
      seg_q   <= '0;
      mask_q  <= KW'(1) << (KW - 1);
    end
    if (cmd_i.search_step) begin
      if (probe_ok) begin
        seg_q <= probe;
      end
      mask_q <= mask_q >> 1;
    end
    if (cmd_i.prep) begin
      num_q  <= MulW'(diff) * MulW'(tti_pkg::SegStep);
      den_q  <= span;
      quot_q <= '0;
      cnt_q  <= CW'(tti_pkg::QuotW - 1);
    end
    if (cmd_i.div_step) begin
      if (num_q >= trial) begin
        num_q         <= num_q - trial;
        quot_q[cnt_q] <= 1'b1;
      end
      cnt_q <= cnt_q - CW'(1);
    end
    if (cmd_i.emit) begin
      temp_q      <= range_q ? tti_pkg::TempW'(temp) : '0;
      range_out_q <= range_q;
      sel_out_q   <= sel_q;
    end
  end

  assign status_o.search_last = mask_q[0];
  assign status_o.div_last    = (cnt_q == '0);

  assign temperature_o = temp_q;
  assign in_range_o    = range_out_q;
  assign sensor_echo_o = sel_out_q;

endmodule

// ===== src/thermistor_table_interpolator.sv =====
// Thermistor table interpolator, top level: controller plus datapath.
// Depends on tti_pkg, tti_if, tti_ctrl and tti_datapath.
//
// Usage: in_i carries one word per ADC sample (adc_code, sensor_select);
// out_o returns one word per sample (temperature_tenths, in_range,
// sensor_echo). Codes outside the selected table's span give in_range = 0
// and a temperature of 0.
// The segment is found by a bitwise search over the table, one probe per
// cycle, ceil(log2(TABLE_ENTRIES-1)) probes (5 by default); then a prepare
// step forms the difference, span and 50x numerator, and a restoring
// divider produces the 6-bit fraction, one bit per cycle, after which the
// result is loaded into the result register that drives out_o.
// One word in flight: in_i.ready rises again in the same cycle that the
// result appears on out_o.
// The result register lets the next word start while a result waits; if
// the receiver stalls, the following result holds in the divider until
// the register frees.
// Reset clears the controller and the output valid; no clearing pass.
module thermistor_table_interpolator #(
  parameter int TABLE_ENTRIES = tti_pkg::TableEntriesDef,
  parameter int NUM_TABLES    = tti_pkg::NumTablesDef
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  tti_in_if.sink    in_i,
  tti_out_if.source out_o
);

  tti_pkg::cmd_t    cmd;
  tti_pkg::status_t status;

  tti_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  tti_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .NUM_TABLES    (NUM_TABLES)
  ) u_datapath (
    .clk_i           (clk_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .adc_code_i      (in_i.adc_code),
    .sensor_select_i (in_i.sensor_select),
    .temperature_o   (out_o.temperature_tenths),
    .in_range_o      (out_o.in_range),
    .sensor_echo_o   (out_o.sensor_echo)
  );

endmodule

// ===== src/tti_checker.sv =====
// Port-level checks for the thermistor table interpolator, bound to the
// top level. Depends on tti_pkg for field widths.
module tti_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_i,
  input logic                             out_valid_i,
  input logic                             out_ready_i,
  input logic signed [tti_pkg::TempW-1:0] temperature_i,
  input logic                             in_range_i,
  input logic                             sensor_echo_i
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(temperature_i) && $stable(in_range_i) &&
      $stable(sensor_echo_i))
    else $error("stalled result word changed");

  // one word in flight: input closes after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input accepted while busy");

  a_zero_out_of_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !in_range_i |-> temperature_i == '0)
    else $error("out-of-range result not zero");

  a_temp_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && in_range_i |->
      temperature_i >= -11'sd200 && temperature_i <= 11'sd1000)
    else $error("temperature outside calibrated span");

endmodule

bind thermistor_table_interpolator tti_checker u_tti_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .temperature_i (out_o.temperature_tenths),
  .in_range_i    (out_o.in_range),
  .sensor_echo_i (out_o.sensor_echo)
);
